// ----- src/hcbp_pkg.sv -----
package hcbp_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_FIELD_W = 8;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [SYM_FIELD_W-1:0] symbol;
        logic [LEN_W-1:0]       code_len;
        logic [CODE_W-1:0]      code_bits;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic                   wr;
        logic [SYM_FIELD_W-1:0] sym;
        logic [LEN_W-1:0]       len;
        logic [CODE_W-1:0]      bits;
    } t_tbl_req;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_rsp;

endpackage

// ----- src/hcbp_ram.sv -----
module hcbp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/hcbp_table.sv -----
module hcbp_table #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcbp_pkg::t_tbl_req i_req,
    output hcbp_pkg::t_tbl_rsp o_rsp
);

    import hcbp_pkg::*;

    localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic [SYMBOL_COUNT-1:0] r_valid;
    logic [SYMBOL_COUNT-1:0] n_valid;
    logic                    r_rd_ok;
    logic [SYM_W-1:0]        idx;
    logic [LEN_W-1:0]        len_raw;
    logic [CODE_W-1:0]       code_raw;

    assign idx = i_req.sym[SYM_W-1:0];

    always_comb begin
        n_valid = r_valid;
        if (i_req.wr) begin
            n_valid[idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_rd_ok <= r_valid[idx];
        end
    end

    hcbp_ram #(
        .WIDTH(LEN_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_len_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_req.wr),
        .i_wr_addr(idx),
        .i_wr_data(i_req.len),
        .i_rd_addr(idx),
        .o_rd_data(len_raw)
    );

    hcbp_ram #(
        .WIDTH(CODE_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_code_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_req.wr),
        .i_wr_addr(idx),
        .i_wr_data(i_req.bits),
        .i_rd_addr(idx),
        .o_rd_data(code_raw)
    );

    assign o_rsp.len  = r_rd_ok ? len_raw : '0;
    assign o_rsp.code = code_raw;

endmodule

// ----- src/huffman_code_bit_packer_unit.sv -----
// Huffman code bit packer. A load request writes the code table. An encode request reads
// the table in ST_READ and then emits each completed byte in ST_EMIT; a flush request
// emits the pending partial byte in ST_FLUSH, or ends without output when nothing is pending.
// The code table memories have a registered read port, and the single output register
// moves one byte per cycle while i_out_stall is low. Output bytes are MSB-first, first
// code bit in bit 7, and the last byte that each request emits is marked. The length
// table is valid from the first cycle after reset; no clearing pass is needed.
module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hcbp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hcbp_pkg::t_out o_out
);

    import hcbp_pkg::*;

    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ACC_W   = CODE_W + 8;
    localparam int CNT_W   = 6;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_pend, n_pend;
    logic [2:0]       r_fill, n_fill;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_sym_ok, n_sym_ok;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_tbl_req         tbl_req;
    t_tbl_rsp         tbl_rsp;

    logic             accept;
    logic             in_range;
    logic [LEN_W-1:0] len_clamped;
    logic             out_free;
    logic [LEN_W-1:0] enc_len;
    logic [CODE_W-1:0] code_left;
    logic [ACC_W-1:0] acc_init;
    logic [CNT_W-1:0] cnt_init;
    logic [CNT_W-1:0] cnt_after;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_in.symbol} < 9'(SYMBOL_COUNT));
    assign len_clamped = (i_in.code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_in.code_len;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign tbl_req.wr   = accept && (i_in.cmd == CMD_LOAD) && in_range;
    assign tbl_req.sym  = i_in.symbol;
    assign tbl_req.len  = len_clamped;
    assign tbl_req.bits = i_in.code_bits;

    hcbp_table #(
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (tbl_req),
        .o_rsp  (tbl_rsp)
    );

    assign enc_len   = r_sym_ok ? tbl_rsp.len : '0;
    assign code_left = tbl_rsp.code << (LEN_W'(CODE_W) - enc_len);
    assign acc_init  = {r_pend, {CODE_W{1'b0}}} | ({code_left, 8'b0} >> r_fill);
    assign cnt_init  = {3'b0, r_fill} + CNT_W'(enc_len);
    assign cnt_after = r_cnt - CNT_W'(8);

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_fill      = r_fill;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_sym_ok    = r_sym_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.cmd)
                        CMD_ENCODE: begin
                            n_sym_ok = in_range;
                            n_state  = ST_READ;
                        end
                        CMD_FLUSH: begin
                            if (r_fill != 3'd0) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (cnt_init >= CNT_W'(8)) begin
                    n_acc   = acc_init;
                    n_cnt   = cnt_init;
                    n_state = ST_EMIT;
                end else begin
                    n_pend  = acc_init[ACC_W-1 -: 8];
                    n_fill  = cnt_init[2:0];
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_byte    = r_acc[ACC_W-1 -: 8];
                    n_out.last_of_run = (cnt_after < CNT_W'(8));
                    n_acc             = r_acc << 8;
                    n_cnt             = cnt_after;
                    if (cnt_after < CNT_W'(8)) begin
                        n_pend  = r_acc[ACC_W-9 -: 8];
                        n_fill  = cnt_after[2:0];
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_byte    = r_pend;
                    n_out.last_of_run = 1'b1;
                    n_pend            = '0;
                    n_fill            = '0;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_sym_ok <= n_sym_ok;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
